### rtl/pfc_pkg.sv
// Shared types, constants and the CRC-16/Modbus byte fold for the pendant frame checker.
package pfc_pkg;

  localparam int unsigned FRAME_LEN = 6;
  localparam int unsigned CRC_LEN   = 4;
  localparam int unsigned CNT_W     = 3;
  localparam int unsigned OUT_W     = 88;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam logic [15:0] SCALE_LOW_RST  = 16'd1;
  localparam logic [15:0] SCALE_MID_RST  = 16'd10;
  localparam logic [15:0] SCALE_HIGH_RST = 16'd100;
  localparam logic [7:0]  ERR_LIMIT_RST  = 8'd10;

  localparam logic [1:0] CFG_SCALE_LOW   = 2'd0;
  localparam logic [1:0] CFG_SCALE_MID   = 2'd1;
  localparam logic [1:0] CFG_SCALE_HIGH  = 2'd2;
  localparam logic [1:0] CFG_ERROR_LIMIT = 2'd3;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_END  = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic valid;
    logic take;
  } hs_t;

  typedef struct packed {
    logic [15:0]        raw_buttons;
    logic [31:0]        lost_count;
    logic [15:0]        scale_sel;
    logic               a_enable;
    logic               z_enable;
    logic               y_enable;
    logic               x_enable;
    logic signed [15:0] position;
    logic               ready_res;
    logic               frame_good;
  } result_t;

  function automatic logic [15:0] crc_fold(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### rtl/pfc_in_stage.sv
// Input register stage: captures one stream transaction and holds it until the core takes it.
module pfc_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [7:0]     in_tdata,
  input  logic           in_tuser,
  input  logic           take,
  output pfc_pkg::item_t item,
  output logic           item_valid
);

  logic           valid_r;
  logic           valid_nxt;
  pfc_pkg::item_t item_r;

  assign in_tready  = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tvalid && in_tready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.action  <= in_tuser;
      item_r.rx_byte <= in_tdata;
    end
  end

endmodule

### rtl/pfc_frame_core.sv
// Frame state, CRC accumulation, frame judgment, config registers and the result register.
module pfc_frame_core (
  input  logic             clk,
  input  logic             rst_n,
  input  pfc_pkg::item_t   item,
  input  pfc_pkg::hs_t     hs_in,
  output logic             take,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data,
  output logic             out_valid,
  input  logic             out_ready,
  output pfc_pkg::result_t result
);

  logic [15:0] scale_low_r, scale_mid_r, scale_high_r;
  logic [7:0]  error_limit_r;

  logic [pfc_pkg::CNT_W-1:0] byte_count_r;
  logic [15:0]               crc_r;
  logic [7:0]                buf_r [pfc_pkg::FRAME_LEN];
  logic [7:0]                bad_run_r, bad_run_nxt;
  logic [31:0]               lost_r, lost_nxt;
  logic [15:0]               pos_r;
  logic [3:0]                en_r;
  logic [15:0]               scale_r, scale_nxt;

  logic              out_valid_r;
  pfc_pkg::result_t  result_r;

  logic        is_end;
  logic        emit;
  logic        good;
  logic [15:0] rx_crc;
  logic [15:0] buttons;
  logic [15:0] position_w;

  assign is_end = (item.action == pfc_pkg::ACT_END);
  assign take   = hs_in.valid && (!is_end || !out_valid_r || out_ready);
  assign emit   = take && is_end;

  assign rx_crc     = {buf_r[5], buf_r[4]};
  assign buttons    = {buf_r[3], buf_r[2]};
  assign position_w = {buf_r[1], buf_r[0]};
  assign good = (byte_count_r == pfc_pkg::CNT_W'(pfc_pkg::FRAME_LEN)) && (rx_crc == crc_r);

  always_comb begin
    if (good) begin
      bad_run_nxt = 8'd0;
      lost_nxt    = lost_r;
    end else begin
      bad_run_nxt = (bad_run_r == 8'hFF) ? bad_run_r : bad_run_r + 8'd1;
      lost_nxt    = lost_r + 32'd1;
    end
  end

  always_comb begin
    if (!buttons[6]) begin
      scale_nxt = scale_high_r;
    end else if (!buttons[5]) begin
      scale_nxt = scale_mid_r;
    end else if (!buttons[4]) begin
      scale_nxt = scale_low_r;
    end else begin
      scale_nxt = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_low_r   <= pfc_pkg::SCALE_LOW_RST;
      scale_mid_r   <= pfc_pkg::SCALE_MID_RST;
      scale_high_r  <= pfc_pkg::SCALE_HIGH_RST;
      error_limit_r <= pfc_pkg::ERR_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pfc_pkg::CFG_SCALE_LOW:   scale_low_r   <= cfg_data;
        pfc_pkg::CFG_SCALE_MID:   scale_mid_r   <= cfg_data;
        pfc_pkg::CFG_SCALE_HIGH:  scale_high_r  <= cfg_data;
        pfc_pkg::CFG_ERROR_LIMIT: error_limit_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      crc_r        <= pfc_pkg::CRC_INIT;
      for (int i = 0; i < pfc_pkg::FRAME_LEN; i++) begin
        buf_r[i] <= 8'd0;
      end
      bad_run_r   <= 8'd0;
      lost_r      <= 32'd0;
      pos_r       <= 16'd0;
      en_r        <= 4'd0;
      scale_r     <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit || (out_valid_r && !out_ready);
      if (take && !is_end) begin
        if (byte_count_r < pfc_pkg::CNT_W'(pfc_pkg::FRAME_LEN)) begin
          buf_r[byte_count_r] <= item.rx_byte;
          if (byte_count_r < pfc_pkg::CNT_W'(pfc_pkg::CRC_LEN)) begin
            crc_r <= pfc_pkg::crc_fold(crc_r, item.rx_byte);
          end
          byte_count_r <= byte_count_r + 1'b1;
        end
      end else if (emit) begin
        byte_count_r <= '0;
        crc_r        <= pfc_pkg::CRC_INIT;
        bad_run_r    <= bad_run_nxt;
        lost_r       <= lost_nxt;
        if (good) begin
          pos_r   <= position_w;
          en_r    <= ~buttons[3:0];
          scale_r <= scale_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result_r.frame_good  <= good;
      result_r.ready_res   <= !(bad_run_nxt > error_limit_r);
      result_r.position    <= good ? position_w : pos_r;
      result_r.x_enable    <= good ? ~buttons[0] : en_r[0];
      result_r.y_enable    <= good ? ~buttons[1] : en_r[1];
      result_r.z_enable    <= good ? ~buttons[2] : en_r[2];
      result_r.a_enable    <= good ? ~buttons[3] : en_r[3];
      result_r.scale_sel   <= good ? scale_nxt : scale_r;
      result_r.lost_count  <= lost_nxt;
      result_r.raw_buttons <= buttons;
    end
  end

  assign out_valid = out_valid_r;
  assign result    = result_r;

endmodule

### rtl/pendant_frame_checker_core.sv
// Top level of the pendant frame checker: stream ports, config port and result packing.
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | tdata rx_byte, tuser action
//  out_    | out | out_tvalid/out_tready| tdata result fields, see port comment
//  cfg_    | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One transaction per cycle is accepted unless an end-of-window item waits on a stalled
// result; items pass the input register, then judgment into the result register.
// Byte transactions produce no result; an end-of-window transaction produces one.
// Reset is synchronous, active low; it restores the config registers and frame state.
// A stalled result holds the result register; byte transactions keep flowing and an
// end-of-window transaction waits in the input register until the result is taken.
// cfg_ready is always high.
module pendant_frame_checker_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] frame_good, [1] ready_res, [17:2] position, [18] x_enable, [19] y_enable,
  // [20] z_enable, [21] a_enable, [37:22] scale_sel, [69:38] lost_count,
  // [85:70] raw_buttons, [87:86] zero
  output logic [87:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  pfc_pkg::item_t   item;
  pfc_pkg::hs_t     hs;
  pfc_pkg::result_t result;
  logic             item_valid;
  logic             take;

  assign cfg_ready = 1'b1;
  assign hs.valid  = item_valid;
  assign hs.take   = take;

  pfc_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .take       (hs.take),
    .item       (item),
    .item_valid (item_valid)
  );

  pfc_frame_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item      (item),
    .hs_in     (hs),
    .take      (take),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .result    (result)
  );

  assign out_tdata = {2'b00, result};

endmodule

### rtl/pfc_checker.sv
// Port-level checker for the pendant frame checker, bound to the top level.
module pfc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [87:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");

  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_good_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[1])
    else $error("good frame reported with ready low");

  a_from_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) && $past(rst_n, 1) && $past(rst_n, 2)
      |-> $past(in_tvalid && in_tready && in_tuser, 2))
    else $error("result without an end-of-window transaction");

endmodule

bind pendant_frame_checker_core pfc_checker u_pfc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
